// ===== rtl/crsf_frame_receiver_unit_defines.svh =====
// Assertion macros for the frame receiver.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef CRSF_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define CRSF_FRAME_RECEIVER_UNIT_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define CRSF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crsf assertion failed");

// The consequent holds in the cycle after the antecedent.
`define CRSF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crsf assertion failed");

`endif

// ===== rtl/crsf_pkg.sv =====
// Shared types and constants for the frame receiver.
// No dependencies; compiled before every other file.
package crsf_pkg;

	localparam int BYTE_W = 8;
	localparam int CNT_W  = 7;
	localparam int POS_W  = 6;

	localparam logic [BYTE_W-1:0] CRC_POLY   = 8'hD5;
	localparam logic [BYTE_W-1:0] MIN_LEN    = 8'd2;
	localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hC8;

	typedef enum logic [1:0] {
		PH_SYNC,
		PH_LEN,
		PH_DATA,
		PH_EMIT
	} phase_t;

	typedef struct packed {
		logic clear;
		logic start;
	} crc_ctrl_t;

endpackage

// ===== rtl/crsf_if.sv =====
// Handshake interfaces for the received-byte, frame-byte and configuration channels.
// Depends on crsf_pkg for field widths.
interface crsf_byte_if import crsf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crsf_frame_if import crsf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] frame_byte;
	logic [POS_W-1:0]  byte_position;
	logic              frame_last;

	modport source (output valid, output frame_byte, output byte_position,
		output frame_last, input ready);
	modport sink   (input valid, input frame_byte, input byte_position,
		input frame_last, output ready);
endinterface

interface crsf_cfg_if import crsf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] sync_value;

	modport source (output valid, output sync_value, input ready);
	modport sink   (input valid, input sync_value, output ready);
endinterface

// ===== rtl/crsf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/crsf_crc_serial.sv =====
// Bit-serial CRC-8 (polynomial 0xD5, MSB first) that folds one byte in one bit at a time.
// Depends on crsf_pkg.
module crsf_crc_serial import crsf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  crc_ctrl_t         ctrl,
	input  logic [BYTE_W-1:0] data,
	output logic              busy,
	output logic [BYTE_W-1:0] crc
);

	logic [BYTE_W-1:0] crc_q;
	logic [BYTE_W-1:0] sh_q;
	logic [2:0]        cnt_q;
	logic              busy_q;
	logic              fb;

	assign fb   = crc_q[BYTE_W-1] ^ sh_q[BYTE_W-1];
	assign busy = busy_q;
	assign crc  = crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			sh_q   <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (ctrl.clear) begin
			crc_q  <= '0;
			busy_q <= 1'b0;
		end else if (ctrl.start) begin
			sh_q   <= data;
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			crc_q <= {crc_q[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
			sh_q  <= {sh_q[BYTE_W-2:0], 1'b0};
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/crsf_frame_receiver_unit.sv =====
// Top level of the frame receiver: sync hunt, length check, CRC check, frame store and replay.
// Depends on crsf_pkg, crsf_if, crsf_ram, crsf_crc_serial and the defines header.
//
// channel  modport  payload                                  role
// rx       sink     rx_byte                                  received bytes
// frame    source   frame_byte, byte_position, frame_last    bytes of good frames
// cfg      sink     sync_value                               sync byte register
//
// After a sync, length or final CRC byte the CRC unit is not busy; after any other
// data byte rx.ready stays low while the serial CRC unit folds it in.
// A good frame of L bytes is replayed from the store; a stall by the sink holds
// the output register and pauses the reads.
// No byte is taken during replay. Reset needs no clearing pass.
`include "crsf_frame_receiver_unit_defines.svh"

module crsf_frame_receiver_unit import crsf_pkg::*; #(
	parameter int FRAME_BYTES = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	crsf_byte_if.sink    rx,
	crsf_frame_if.source frame,
	crsf_cfg_if.sink     cfg
);

	localparam int AW = $clog2(FRAME_BYTES);
	localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(FRAME_BYTES);

	phase_t            state_q, state_d;
	logic [BYTE_W-1:0] sync_q;
	logic [CNT_W-1:0]  remaining_q;
	logic [CNT_W-1:0]  wpos_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  issue_q;
	logic [POS_W-1:0]  pos_q;
	logic              last_q;
	logic              out_valid_q;

	logic              in_fire;
	logic              ram_we;
	logic              ram_re;
	logic              len_ok;
	logic              crc_match;
	logic              crc_busy;
	logic [BYTE_W-1:0] crc_val;
	crc_ctrl_t         crc_ctrl;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg.valid) begin
			sync_q <= cfg.sync_value;
		end
	end

	assign in_fire   = rx.valid && rx.ready;
	assign len_ok    = (rx.rx_byte >= MIN_LEN) && (rx.rx_byte <= MAX_LEN);
	assign crc_match = (rx.rx_byte == crc_val);

	always_comb begin
		state_d       = state_q;
		rx.ready      = (state_q != PH_EMIT) && !crc_busy;
		ram_we        = 1'b0;
		ram_re        = 1'b0;
		crc_ctrl      = '0;
		unique case (state_q)
			PH_SYNC: begin
				if (in_fire && (rx.rx_byte == sync_q)) begin
					state_d = PH_LEN;
				end
			end
			PH_LEN: begin
				if (in_fire) begin
					if (len_ok) begin
						state_d        = PH_DATA;
						crc_ctrl.clear = 1'b1;
					end else begin
						state_d = PH_SYNC;
					end
				end
			end
			PH_DATA: begin
				if (in_fire) begin
					if (remaining_q == '0) begin
						state_d = PH_SYNC;
					end else begin
						ram_we = 1'b1;
						if (remaining_q == CNT_W'(1)) begin
							state_d = crc_match ? PH_EMIT : PH_SYNC;
						end else begin
							crc_ctrl.start = 1'b1;
						end
					end
				end
			end
			PH_EMIT: begin
				ram_re = (issue_q != total_q) && (!out_valid_q || frame.ready);
				if ((issue_q == total_q) && (!out_valid_q || frame.ready)) begin
					state_d = PH_SYNC;
				end
			end
			default: state_d = PH_SYNC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_SYNC;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			wpos_q      <= '0;
			total_q     <= '0;
			issue_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire && (state_q == PH_LEN) && len_ok) begin
				remaining_q <= rx.rx_byte[CNT_W-1:0];
				wpos_q      <= '0;
			end
			if (ram_we) begin
				remaining_q <= remaining_q - CNT_W'(1);
				wpos_q      <= wpos_q + CNT_W'(1);
				total_q     <= wpos_q + CNT_W'(1);
				issue_q     <= '0;
			end
			if (ram_re) begin
				issue_q     <= issue_q + CNT_W'(1);
				out_valid_q <= 1'b1;
			end else if (frame.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			pos_q  <= issue_q[POS_W-1:0];
			last_q <= (issue_q + CNT_W'(1)) == total_q;
		end
	end

	crsf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (FRAME_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wpos_q[AW-1:0]),
		.wdata (rx.rx_byte),
		.re    (ram_re),
		.raddr (issue_q[AW-1:0]),
		.rdata (frame.frame_byte)
	);

	crsf_crc_serial u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (crc_ctrl),
		.data   (rx.rx_byte),
		.busy   (crc_busy),
		.crc    (crc_val)
	);

	assign frame.valid         = out_valid_q;
	assign frame.byte_position = pos_q;
	assign frame.frame_last    = last_q;

	// No byte may be taken while the CRC unit is still folding in the previous one.
	`CRSF_ASSERT_SAME(a_no_take_while_crc, crc_busy, !rx.ready)
	`CRSF_ASSERT_SAME(a_out_only_in_emit, frame.valid, state_q == PH_EMIT)
	`CRSF_ASSERT_SAME(a_issue_bound, state_q == PH_EMIT, issue_q <= total_q)
	// Within a frame the replay never leaves a gap after a byte is taken.
	`CRSF_ASSERT_NEXT(a_no_gap, frame.valid && frame.ready && !frame.frame_last, frame.valid)

endmodule
